FILE: hdl/mhsb_pkg.sv
`default_nettype none
package mhsb_pkg;

   localparam int HashCount = 11;
   localparam int MaxDigits = 10;
   localparam int DigitW    = 4;
   localparam int CntW      = 4;

   localparam int HRs   = 0;
   localparam int HJs   = 1;
   localparam int HPjw  = 2;
   localparam int HElf  = 3;
   localparam int HBkdr = 4;
   localparam int HSdbm = 5;
   localparam int HDjb  = 6;
   localparam int HDek  = 7;
   localparam int HBp   = 8;
   localparam int HFnv  = 9;
   localparam int HAp   = 10;

   localparam logic [31:0] OffsetReset = 32'd10000;

   typedef logic [HashCount-1:0][31:0] hash_vec_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_CONV,
      S_HASH,
      S_FOLD
   } state_type;

   typedef struct packed {
      logic             init;
      logic             step;
      logic [CntW-1:0]  len;
      logic [7:0]       chr;
      logic             odd;
   } hash_ctl_type;

endpackage
`default_nettype wire

FILE: hdl/minhash_signature_builder_top.sv
`default_nettype none
// channel  | valid      | flow control | payload
// req      | req_valid  | req_stall    | req_user_id, req_item_index, req_last_user
// rsp      | rsp_valid  | rsp_stall    | rsp_item_tag, rsp_min_*
// csr      | csr_valid  | csr_ready    | csr_id_offset
// A user passes S_CONV, S_HASH and S_FOLD; n = decimal digits of id + offset
// (1..10), the digit chain takes n digits in S_CONV and hashes n in S_HASH.
// Reset is synchronous: minima return to all ones, offset to 10000.
// req_stall is high while a user is in work; a held result only stalls the
// fold of the next closing user.
module minhash_signature_builder_top (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [31:0] req_user_id,
   input  wire  [23:0] req_item_index,
   input  wire         req_last_user,
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [23:0] rsp_item_tag,
   output logic [31:0] rsp_min_rs,
   output logic [31:0] rsp_min_js,
   output logic [31:0] rsp_min_pjw,
   output logic [31:0] rsp_min_elf,
   output logic [31:0] rsp_min_bkdr,
   output logic [31:0] rsp_min_sdbm,
   output logic [31:0] rsp_min_djb,
   output logic [31:0] rsp_min_dek,
   output logic [31:0] rsp_min_bp,
   output logic [31:0] rsp_min_fnv,
   output logic [31:0] rsp_min_ap,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [31:0] csr_id_offset
);
   import mhsb_pkg::*;

   state_type         state_ff, state_in;
   logic [31:0]       offset_ff, offset_in;
   logic [31:0]       val_ff, val_in;
   logic [23:0]       item_ff, item_in;
   logic              last_ff, last_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic              odd_ff, odd_in;
   hash_vec_type      min_ff, min_in;
   hash_vec_type      hash_w;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [23:0]       tag_ff, tag_in;
   hash_vec_type      out_ff, out_in;
   hash_ctl_type      hctl;
   logic              shift_up, shift_down;
   logic [63:0]       prod;
   logic [31:0]       quot;
   logic [31:0]       rem;
   logic [DigitW-1:0] digit [MaxDigits];
   logic [DigitW-1:0] new_digit;

   assign prod      = {32'd0, val_ff} * 64'h00000000CCCCCCCD;
   assign quot      = {3'd0, prod[63:35]};
   assign rem       = val_ff - ((quot << 3) + (quot << 1));
   assign new_digit = rem[DigitW-1:0];

   genvar k;
   generate
      for (k = 0; k < MaxDigits; k++) begin : g_cell
         if (k == 0) begin : g_first
            mhsb_digit_cell u_cell (
               .clock(clock), .shift_up(shift_up), .shift_down(shift_down),
               .from_low(new_digit), .from_high(digit[k+1]), .digit_ff(digit[k])
            );
         end else if (k == MaxDigits - 1) begin : g_last
            mhsb_digit_cell u_cell (
               .clock(clock), .shift_up(shift_up), .shift_down(shift_down),
               .from_low(digit[k-1]), .from_high({DigitW{1'b0}}),
               .digit_ff(digit[k])
            );
         end else begin : g_mid
            mhsb_digit_cell u_cell (
               .clock(clock), .shift_up(shift_up), .shift_down(shift_down),
               .from_low(digit[k-1]), .from_high(digit[k+1]), .digit_ff(digit[k])
            );
         end
      end
   endgenerate

   mhsb_hash_unit u_hash (
      .clock(clock),
      .ctl(hctl),
      .hash_ff(hash_w)
   );

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item_tag = tag_ff;
   assign rsp_min_rs   = out_ff[HRs];
   assign rsp_min_js   = out_ff[HJs];
   assign rsp_min_pjw  = out_ff[HPjw];
   assign rsp_min_elf  = out_ff[HElf];
   assign rsp_min_bkdr = out_ff[HBkdr];
   assign rsp_min_sdbm = out_ff[HSdbm];
   assign rsp_min_djb  = out_ff[HDjb];
   assign rsp_min_dek  = out_ff[HDek];
   assign rsp_min_bp   = out_ff[HBp];
   assign rsp_min_fnv  = out_ff[HFnv];
   assign rsp_min_ap   = out_ff[HAp];

   always_comb begin
      state_in     = state_ff;
      offset_in    = offset_ff;
      val_in       = val_ff;
      item_in      = item_ff;
      last_in      = last_ff;
      cnt_in       = cnt_ff;
      odd_in       = odd_ff;
      min_in       = min_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      tag_in       = tag_ff;
      out_in       = out_ff;
      shift_up     = 1'b0;
      shift_down   = 1'b0;
      hctl         = '0;
      hctl.len     = cnt_ff + 1'b1;
      hctl.chr     = 8'd48 + {4'd0, digit[0]};
      hctl.odd     = odd_ff;
      if (csr_valid) begin
         offset_in = csr_id_offset;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               val_in   = req_user_id + offset_ff;
               item_in  = req_item_index;
               last_in  = req_last_user;
               cnt_in   = '0;
               state_in = S_CONV;
            end
         end
         S_CONV: begin
            shift_up = 1'b1;
            val_in   = quot;
            cnt_in   = cnt_ff + 1'b1;
            if (quot == 32'd0 || cnt_ff == CntW'(MaxDigits - 1)) begin
               hctl.init = 1'b1;
               odd_in    = 1'b0;
               state_in  = S_HASH;
            end
         end
         S_HASH: begin
            hctl.step  = 1'b1;
            shift_down = 1'b1;
            odd_in     = !odd_ff;
            cnt_in     = cnt_ff - 1'b1;
            if (cnt_ff == CntW'(1)) begin
               state_in = S_FOLD;
            end
         end
         S_FOLD: begin
            for (int i = 0; i < HashCount; i++) begin
               if (hash_w[i] < min_ff[i]) begin
                  min_in[i] = hash_w[i];
               end
            end
            if (!last_ff) begin
               state_in = S_IDLE;
            end else if (!(rsp_valid_ff && rsp_stall)) begin
               out_in       = min_in;
               tag_in       = item_ff;
               rsp_valid_in = 1'b1;
               min_in       = '1;
               state_in     = S_IDLE;
            end else begin
               min_in = min_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         offset_ff    <= OffsetReset;
         min_ff       <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         offset_ff    <= offset_in;
         min_ff       <= min_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff  <= val_in;
      item_ff <= item_in;
      last_ff <= last_in;
      cnt_ff  <= cnt_in;
      odd_ff  <= odd_in;
      tag_ff  <= tag_in;
      out_ff  <= out_in;
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CONV || state_ff == S_HASH) |-> cnt_ff <= CntW'(MaxDigits))
      else $error("digit count out of range");
   a_hash_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_HASH |-> cnt_ff != '0)
      else $error("hash phase with no digits");
   a_rsp_from_fold: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FOLD && last_ff))
      else $error("result raised outside fold of a closing user");
   a_min_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FOLD && last_ff && !(rsp_valid_ff && rsp_stall))
      |=> min_ff == '1)
      else $error("minima not cleared after result");
`endif

endmodule
`default_nettype wire

FILE: hdl/mhsb_digit_cell.sv
`default_nettype none
module mhsb_digit_cell (
   input  wire                       clock,
   input  wire                       shift_up,
   input  wire                       shift_down,
   input  wire [mhsb_pkg::DigitW-1:0] from_low,
   input  wire [mhsb_pkg::DigitW-1:0] from_high,
   output logic [mhsb_pkg::DigitW-1:0] digit_ff
);
   import mhsb_pkg::*;

   logic [DigitW-1:0] digit_in;

   always_comb begin
      digit_in = digit_ff;
      if (shift_up) begin
         digit_in = from_low;
      end else if (shift_down) begin
         digit_in = from_high;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule
`default_nettype wire

FILE: hdl/mhsb_hash_unit.sv
`default_nettype none
module mhsb_hash_unit (
   input  wire                         clock,
   input  wire mhsb_pkg::hash_ctl_type ctl,
   output mhsb_pkg::hash_vec_type      hash_ff
);
   import mhsb_pkg::*;

   hash_vec_type hash_in;
   logic [31:0]  a_ff;
   logic [31:0]  a_in;
   logic [31:0]  c;
   logic [31:0]  p;
   logic [31:0]  e;
   logic [31:0]  t;
   logic [31:0]  ap;
   logic [31:0]  s;

   always_comb begin
      hash_in = hash_ff;
      a_in    = a_ff;
      c       = {24'd0, ctl.chr};
      p       = '0;
      e       = '0;
      t       = '0;
      ap      = hash_ff[HAp];
      s       = hash_ff[HSdbm];
      if (ctl.init) begin
         hash_in        = '0;
         hash_in[HJs]   = 32'd1315423911;
         hash_in[HDjb]  = 32'd5381;
         hash_in[HDek]  = {28'd0, ctl.len};
         hash_in[HAp]   = 32'hAAAAAAAA;
         a_in           = 32'd63689;
      end else if (ctl.step) begin
         hash_in[HRs] = hash_ff[HRs] * a_ff + c;
         a_in         = a_ff * 32'd378551;
         hash_in[HJs] = hash_ff[HJs] ^
                        ((hash_ff[HJs] << 5) + c + (hash_ff[HJs] >> 2));
         p = (hash_ff[HPjw] << 4) + c;
         t = p & 32'hF0000000;
         if (t != 32'd0) begin
            p = (p ^ (t >> 24)) & 32'h0FFFFFFF;
         end
         hash_in[HPjw] = p;
         e = (hash_ff[HElf] << 4) + c;
         t = e & 32'hF0000000;
         if (t != 32'd0) begin
            e = e ^ (t >> 24);
         end
         hash_in[HElf]  = e & ~t;
         hash_in[HBkdr] = (hash_ff[HBkdr] << 7) + (hash_ff[HBkdr] << 1)
                          + hash_ff[HBkdr] + c;
         hash_in[HSdbm] = c + (s << 6) + (s << 16) - s;
         hash_in[HDjb]  = (hash_ff[HDjb] << 5) + hash_ff[HDjb] + c;
         hash_in[HDek]  = ((hash_ff[HDek] << 5) ^ (hash_ff[HDek] >> 27)) ^ c;
         hash_in[HBp]   = (hash_ff[HBp] << 7) ^ c;
         hash_in[HFnv]  = (hash_ff[HFnv] * 32'h811C9DC5) ^ c;
         if (!ctl.odd) begin
            hash_in[HAp] = ap ^ ((ap << 7) ^ (c * (ap >> 3)));
         end else begin
            hash_in[HAp] = ap ^ ~((ap << 11) + (c ^ (ap >> 5)));
         end
      end
   end

   always_ff @(posedge clock) begin
      hash_ff <= hash_in;
      a_ff    <= a_in;
   end

endmodule
`default_nettype wire

FILE: bench/tb_minhash_signature_builder_top.sv
`timescale 1ns / 100ps
module tb_minhash_signature_builder_top;
   import mhsb_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_user_id;
   logic [23:0] req_item_index;
   logic        req_last_user;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [23:0] rsp_item_tag;
   logic [31:0] rsp_min_rs, rsp_min_js, rsp_min_pjw, rsp_min_elf, rsp_min_bkdr;
   logic [31:0] rsp_min_sdbm, rsp_min_djb, rsp_min_dek, rsp_min_bp, rsp_min_fnv;
   logic [31:0] rsp_min_ap;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_id_offset;

   typedef struct packed {
      logic [23:0]  tag;
      hash_vec_type mins;
   } signature_type;

   logic [31:0]   offset_model;
   hash_vec_type  minima_model;
   signature_type signature_queue[$];
   int            errors;
   int            stall_pct;
   int            stall_hold;
   string         hash_names[HashCount] = '{"min_rs", "min_js", "min_pjw", "min_elf",
      "min_bkdr", "min_sdbm", "min_djb", "min_dek", "min_bp", "min_fnv", "min_ap"};

   minhash_signature_builder_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_user_id(req_user_id),
      .req_item_index(req_item_index), .req_last_user(req_last_user),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item_tag(rsp_item_tag),
      .rsp_min_rs(rsp_min_rs), .rsp_min_js(rsp_min_js), .rsp_min_pjw(rsp_min_pjw),
      .rsp_min_elf(rsp_min_elf), .rsp_min_bkdr(rsp_min_bkdr),
      .rsp_min_sdbm(rsp_min_sdbm), .rsp_min_djb(rsp_min_djb),
      .rsp_min_dek(rsp_min_dek), .rsp_min_bp(rsp_min_bp), .rsp_min_fnv(rsp_min_fnv),
      .rsp_min_ap(rsp_min_ap),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_id_offset(csr_id_offset)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic hash_vec_type string_hashes(input logic [31:0] value);
      logic [7:0]   chars[10];
      logic [7:0]   rev[10];
      int           n;
      logic [31:0]  v, c, t, a;
      logic [31:0]  rs, js, pjw, elf, bkdr, sdbm, djb, dek, bp, fnv, ap;
      hash_vec_type h;
      n = 0;
      v = value;
      do begin
         rev[n] = 8'd48 + 8'(v % 10);
         n++;
         v = v / 10;
      end while (v != 0 && n < MaxDigits);
      for (int i = 0; i < n; i++) chars[i] = rev[n - 1 - i];
      rs = 0; a = 63689; js = 1315423911; pjw = 0; elf = 0; bkdr = 0; sdbm = 0;
      djb = 5381; dek = n; bp = 0; fnv = 0; ap = 32'hAAAAAAAA;
      for (int i = 0; i < n; i++) begin
         c = {24'd0, chars[i]};
         rs = rs * a + c;
         a = a * 378551;
         js ^= (js << 5) + c + (js >> 2);
         pjw = (pjw << 4) + c;
         t = pjw & 32'hF0000000;
         if (t != 0) pjw = (pjw ^ (t >> 24)) & 32'h0FFFFFFF;
         elf = (elf << 4) + c;
         t = elf & 32'hF0000000;
         if (t != 0) elf ^= t >> 24;
         elf &= ~t;
         bkdr = bkdr * 131 + c;
         sdbm = c + (sdbm << 6) + (sdbm << 16) - sdbm;
         djb = (djb << 5) + djb + c;
         dek = ((dek << 5) ^ (dek >> 27)) ^ c;
         bp = (bp << 7) ^ c;
         fnv = fnv * 32'h811C9DC5;
         fnv ^= c;
         if ((i & 1) == 0) ap ^= (ap << 7) ^ (c * (ap >> 3));
         else ap ^= ~((ap << 11) + (c ^ (ap >> 5)));
      end
      h[HRs] = rs; h[HJs] = js; h[HPjw] = pjw; h[HElf] = elf; h[HBkdr] = bkdr;
      h[HSdbm] = sdbm; h[HDjb] = djb; h[HDek] = dek; h[HBp] = bp;
      h[HFnv] = fnv; h[HAp] = ap;
      return h;
   endfunction

   function automatic void fold_user(input logic [31:0] uid, input logic [23:0] item,
                                     input logic last);
      hash_vec_type  h;
      signature_type s;
      h = string_hashes(uid + offset_model);
      for (int i = 0; i < HashCount; i++)
         if (h[i] < minima_model[i]) minima_model[i] = h[i];
      if (last) begin
         s.tag = item;
         s.mins = minima_model;
         signature_queue = {signature_queue, s};
         minima_model = '1;
      end
   endfunction

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if ($urandom_range(0, 2) == 0) n = 0;
      repeat (n) @(negedge clock);
   endtask

   task automatic send_user(input logic [31:0] uid, input logic [23:0] item,
                            input logic last);
      req_valid = 1'b1;
      req_user_id = uid;
      req_item_index = item;
      req_last_user = last;
      do @(posedge clock); while (req_stall);
      fold_user(uid, item, last);
      @(negedge clock);
      req_valid = 1'b0;
      idle_gap();
   endtask

   task automatic drain();
      while (signature_queue.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   task automatic write_offset(input logic [31:0] value);
      drain();
      csr_valid = 1'b1;
      csr_id_offset = value;
      do @(posedge clock); while (!csr_ready);
      offset_model = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // check each result transfer against the oldest signature
   always @(posedge clock) begin
      signature_type e;
      hash_vec_type  got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got[HRs] = rsp_min_rs; got[HJs] = rsp_min_js; got[HPjw] = rsp_min_pjw;
         got[HElf] = rsp_min_elf; got[HBkdr] = rsp_min_bkdr;
         got[HSdbm] = rsp_min_sdbm; got[HDjb] = rsp_min_djb; got[HDek] = rsp_min_dek;
         got[HBp] = rsp_min_bp; got[HFnv] = rsp_min_fnv; got[HAp] = rsp_min_ap;
         if (signature_queue.size() == 0) begin
            $error("unexpected result transfer, item_tag %0h", rsp_item_tag);
            errors++;
         end else begin
            e = signature_queue.pop_front();
            if (rsp_item_tag !== e.tag) begin
               $error("item_tag expected %0h actual %0h", e.tag, rsp_item_tag);
               errors++;
            end
            for (int i = 0; i < HashCount; i++)
               if (got[i] !== e.mins[i]) begin
                  $error("%s expected %0h actual %0h", hash_names[i], e.mins[i],
                         got[i]);
                  errors++;
               end
         end
      end
   end

   always @(negedge clock) begin
      if (stall_hold > 0) begin
         rsp_stall <= 1'b1;
         stall_hold <= stall_hold - 1;
      end else if ($urandom_range(0, 149) == 0) begin
         rsp_stall <= 1'b1;
         stall_hold <= $urandom_range(10, 60);
      end else if (stall_pct == 0) rsp_stall <= 1'b0;
      else if ($urandom_range(0, 49) == 0) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(0, 99) < stall_pct);
   end

   always @(negedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_pct <= 0;
      else if ($urandom_range(0, 199) == 0) stall_pct <= $urandom_range(0, 60);
   end

   task automatic test_directed();
      send_user(32'd0, 24'd0, 1'b1);
      send_user(32'hFFFFFFFF, 24'hFFFFFF, 1'b1);
      send_user(32'd12345, 24'd1, 1'b0);
      send_user(32'd7, 24'd1, 1'b0);
      send_user(32'hFFFF_D8F0, 24'd1, 1'b1);
      send_user(32'hAAAAAAAA, 24'h555555, 1'b0);
      send_user(32'h55555555, 24'hAAAAAA, 1'b1);
   endtask

   task automatic test_offsets();
      logic [31:0] offs[4];
      offs = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'hFFFFFFF6};
      foreach (offs[k]) begin
         write_offset(offs[k]);
         send_user(32'd0, 24'd2, 1'b1);
         send_user(32'd9, 24'd3, 1'b0);
         send_user(32'd10, 24'd3, 1'b1);
         send_user(32'hFFFFFFFF, 24'd4, 1'b1);
      end
   endtask

   task automatic test_pause();
      send_user($urandom, 24'd5, 1'b1);
      drain();
      send_user($urandom, 24'd6, 1'b1);
   endtask

   function automatic logic [31:0] random_id();
      case ($urandom_range(0, 3))
         0: return $urandom_range(0, 20);
         1: return $urandom_range(0, 99999);
         2: return 32'hFFFFFFFF - $urandom_range(0, 20000);
         default: return $urandom;
      endcase
   endfunction

   task automatic test_random();
      int          sent;
      int          users;
      logic [23:0] item;
      sent = 0;
      while (sent < 700) begin
         if ($urandom_range(0, 7) == 0) write_offset($urandom_range(0, 3) == 0 ?
            $urandom_range(0, 20000) : $urandom);
         item = 24'($urandom);
         users = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
         for (int u = 0; u < users; u++) begin
            send_user(random_id(), item, u == users - 1);
            sent++;
         end
      end
   endtask

   initial begin
      errors = 0;
      stall_pct = 20;
      reset = 1'b1;
      req_valid = 1'b0;
      req_user_id = '0;
      req_item_index = '0;
      req_last_user = 1'b0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_id_offset = '0;
      offset_model = OffsetReset;
      minima_model = '1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_pause();
      test_offsets();
      test_random();
      drain();
      if (errors == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #4000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

FILE: filelist.f
hdl/mhsb_pkg.sv
hdl/mhsb_digit_cell.sv
hdl/mhsb_hash_unit.sv
hdl/minhash_signature_builder_top.sv
bench/tb_minhash_signature_builder_top.sv
